FILE: sv/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants
// Step codes, arithmetic unit operations, controller/datapath command and
// status structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package csf_pkg;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT,
		OP_DIVK
	} csf_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_KX, ST_DX, ST_AX, ST_VX,
		ST_KY, ST_DY, ST_AY, ST_VY,
		ST_VMX, ST_VMY, ST_VLIM, ST_VSQ,
		ST_VSX, ST_VDX, ST_VSY, ST_VDY,
		ST_PMX, ST_PDX, ST_PMY, ST_PDY,
		ST_LMX, ST_LMY, ST_LLIM, ST_LSQ,
		ST_LSX, ST_LDX, ST_LSY, ST_LDY,
		ST_CLAMP,
		ST_OUT
	} csf_state_t;

	typedef struct packed {
		csf_state_t step;
		logic       start;
		logic       load;
		logic       emit;
	} csf_cmd_t;

	typedef struct packed {
		logic done;
		logic big;
		logic rem_zero;
		logic step_zero;
	} csf_sts_t;

	localparam logic [1:0] REG_STIFFNESS = 2'd0;
	localparam logic [1:0] REG_DAMPING   = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED = 2'd2;
	localparam logic [1:0] REG_MAX_LAG   = 2'd3;

	localparam logic [15:0] STIFFNESS_RST = 16'd20992;
	localparam logic [15:0] DAMPING_RST   = 16'd3617;
	localparam logic [19:0] MAX_SPEED_RST = 20'd196608;
	localparam logic [16:0] MAX_LAG_RST   = 17'd3932;

	localparam logic [16:0] POS_ONE    = 17'd65536;
	localparam logic [18:0] POS_CENTRE = 19'd32768;

	// 256000000 = 2^14 * 15625 and 1000000 = 2^6 * 15625
	localparam logic signed [63:0] ACC_SHIFT = 64'sd14;
	localparam logic signed [63:0] US_SHIFT  = 64'sd6;
	localparam logic [63:0]        DIVK_BASE  = 64'd15625;
	// floor(2^36 / 15625)
	localparam logic [63:0]        DIVK_RECIP = 64'd4398046;

endpackage

FILE: sv/csf_arith.sv
// ----------------------------------------------------------------------------
// csf_arith: shared iterative arithmetic unit
// Signed shift-add multiply (32 steps), signed restoring divide truncating
// toward zero (64 steps), ceiling square root (32 steps) and a signed divide
// by a power of two times 15625: shift, reciprocal multiply and up to ten
// compare-and-subtract corrections (43 steps), one step a cycle.
// ----------------------------------------------------------------------------
module csf_arith (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  csf_pkg::csf_op_t      op,
	input  logic signed [63:0]    a,
	input  logic signed [63:0]    b,
	output logic                  done,
	output logic signed [63:0]    res
);
	import csf_pkg::*;

	logic           busy_q, fin_q, done_q, neg_q;
	logic [6:0]     cnt_q;
	csf_op_t        op_q;
	logic [63:0]    x_q, y_q, z_q, m_q;
	logic [63:0]    res_q;
	logic [63:0]    mag_a, mag_b;
	logic [63:0]    mul_sum, div_sh, div_diff, sq_t, sq_diff, raw;
	logic [63:0]    q0_w, q0_d, r0;
	logic           div_ge, sq_ge, kc_ge;

	always_comb begin
		mag_a    = a[63] ? (~a + 64'd1) : a;
		mag_b    = b[63] ? (~b + 64'd1) : b;
		mul_sum  = x_q + y_q;
		div_sh   = {x_q[62:0], y_q[63]};
		div_ge   = div_sh >= z_q;
		div_diff = div_sh - z_q;
		sq_t     = y_q + z_q;
		sq_ge    = x_q >= sq_t;
		sq_diff  = x_q - sq_t;
		// estimate never exceeds the quotient; 15625 = 2^14 - 2^10 + 2^8 + 2^3 + 1
		q0_w     = {36'd0, x_q[63:36]};
		q0_d     = (q0_w << 14) - (q0_w << 10) + (q0_w << 8) + (q0_w << 3) + q0_w;
		r0       = m_q - q0_d;
		kc_ge    = x_q >= DIVK_BASE;
		unique case (op_q)
			OP_MUL:  raw = x_q;
			OP_DIV:  raw = y_q;
			OP_SQRT: raw = y_q + 64'(x_q != 64'd0);
			OP_DIVK: raw = y_q;
			default: raw = x_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= op;
				cnt_q  <= (op == OP_DIV) ? 7'd64 : ((op == OP_DIVK) ? 7'd43 : 7'd32);
				neg_q  <= (op != OP_SQRT) && (a[63] ^ b[63]);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			unique case (op)
				OP_MUL: begin
					x_q <= '0;
					y_q <= mag_a;
					z_q <= mag_b;
				end
				OP_DIV: begin
					x_q <= '0;
					y_q <= mag_a;
					z_q <= mag_b;
				end
				OP_SQRT: begin
					x_q <= a;
					y_q <= '0;
					z_q <= 64'd1 << 62;
				end
				OP_DIVK: begin
					x_q <= '0;
					y_q <= mag_a >> b[5:0];
					z_q <= DIVK_RECIP;
					m_q <= mag_a >> b[5:0];
				end
				default: begin
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL: begin
					if (z_q[0])
						x_q <= mul_sum;
					y_q <= y_q << 1;
					z_q <= z_q >> 1;
				end
				OP_DIV: begin
					// quotient bits shift in behind the numerator
					x_q <= div_ge ? div_diff : div_sh;
					y_q <= {y_q[62:0], div_ge};
				end
				OP_SQRT: begin
					if (sq_ge) begin
						x_q <= sq_diff;
						y_q <= (y_q >> 1) + z_q;
					end else begin
						y_q <= y_q >> 1;
					end
					z_q <= z_q >> 2;
				end
				OP_DIVK: begin
					if (cnt_q > 7'd11) begin
						if (z_q[0])
							x_q <= mul_sum;
						y_q <= y_q << 1;
						z_q <= z_q >> 1;
					end else if (cnt_q == 7'd11) begin
						x_q <= r0;
						y_q <= q0_w;
					end else if (kc_ge) begin
						// settle the estimate one count at a time
						x_q <= x_q - DIVK_BASE;
						y_q <= y_q + 64'd1;
					end
				end
				default: begin
					x_q <= x_q;
				end
			endcase
		end
		if (fin_q)
			res_q <= neg_q ? (~raw + 64'd1) : raw;
	end

	assign done = done_q;
	assign res  = $signed(res_q);

endmodule

FILE: sv/csf_datapath.sv
// ----------------------------------------------------------------------------
// csf_datapath: spring follower datapath
// Configuration registers, pointer state, working registers, operand
// selection for the shared arithmetic unit and the output register.
// ----------------------------------------------------------------------------
module csf_datapath #(
	parameter int unsigned MAX_STEP_US = 16000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic [16:0]         target_x,
	input  logic [16:0]         target_y,
	input  logic [15:0]         step_us,
	input  logic                restart,
	input  csf_pkg::csf_cmd_t   cmd,
	output csf_pkg::csf_sts_t   sts,
	output logic [16:0]         pos_x,
	output logic [16:0]         pos_y,
	output logic signed [20:0]  vel_x,
	output logic signed [20:0]  vel_y
);
	import csf_pkg::*;

	localparam logic [15:0] MAX_DT = 16'(MAX_STEP_US);

	logic [15:0]         stiff_q, damp_q;
	logic [19:0]         mspd_q;
	logic [16:0]         mlag_q;
	logic signed [18:0]  px_q, py_q;
	logic signed [26:0]  vx_q, vy_q;
	logic [16:0]         tx_q, ty_q;
	logic [15:0]         dt_q, rem_q;
	logic signed [63:0]  tmp_q;
	logic [63:0]         mag_q;
	logic [26:0]         s_q;
	logic [16:0]         pos_x_q, pos_y_q;
	logic [20:0]         vel_x_q, vel_y_q;

	logic [16:0]         tx_sat, ty_sat;
	logic [15:0]         in_dt, rem_dt;
	logic signed [19:0]  dx, dy;
	logic                op_start, done;
	csf_op_t             op_code;
	logic signed [63:0]  op_a, op_b, res;
	logic signed [18:0]  px_cl, py_cl;
	logic                x_lo, x_hi, y_lo, y_hi, vx_zero, vy_zero;

	assign tx_sat = (target_x > POS_ONE) ? POS_ONE : target_x;
	assign ty_sat = (target_y > POS_ONE) ? POS_ONE : target_y;
	assign in_dt  = (step_us > MAX_DT) ? MAX_DT : step_us;
	assign rem_dt = (rem_q > MAX_DT) ? MAX_DT : rem_q;
	assign dx     = 20'($signed({3'b000, tx_q})) - 20'(px_q);
	assign dy     = 20'($signed({3'b000, ty_q})) - 20'(py_q);

	always_comb begin
		op_code = OP_MUL;
		op_a    = '0;
		op_b    = '0;
		unique case (cmd.step)
			ST_KX:  begin op_a = {48'd0, stiff_q}; op_b = 64'(dx); end
			ST_KY:  begin op_a = {48'd0, stiff_q}; op_b = 64'(dy); end
			ST_DX:  begin op_a = {48'd0, damp_q};  op_b = 64'(vx_q); end
			ST_DY:  begin op_a = {48'd0, damp_q};  op_b = 64'(vy_q); end
			ST_AX, ST_AY, ST_PMX, ST_PMY: begin
				op_a = tmp_q;
				op_b = {48'd0, dt_q};
				if (cmd.step == ST_PMX)
					op_a = 64'(vx_q);
				else if (cmd.step == ST_PMY)
					op_a = 64'(vy_q);
			end
			ST_VX, ST_VY: begin
				op_code = OP_DIVK;
				op_a    = tmp_q;
				op_b    = ACC_SHIFT;
			end
			ST_PDX, ST_PDY: begin
				op_code = OP_DIVK;
				op_a    = tmp_q;
				op_b    = US_SHIFT;
			end
			ST_VMX: begin op_a = 64'(vx_q); op_b = 64'(vx_q); end
			ST_VMY: begin op_a = 64'(vy_q); op_b = 64'(vy_q); end
			ST_VLIM: begin op_a = {44'd0, mspd_q}; op_b = {44'd0, mspd_q}; end
			ST_VSX: begin op_a = 64'(vx_q); op_b = {44'd0, mspd_q}; end
			ST_VSY: begin op_a = 64'(vy_q); op_b = {44'd0, mspd_q}; end
			ST_LMX: begin op_a = 64'(dx); op_b = 64'(dx); end
			ST_LMY: begin op_a = 64'(dy); op_b = 64'(dy); end
			ST_LLIM: begin op_a = {47'd0, mlag_q}; op_b = {47'd0, mlag_q}; end
			ST_LSX: begin op_a = 64'(dx); op_b = {47'd0, mlag_q}; end
			ST_LSY: begin op_a = 64'(dy); op_b = {47'd0, mlag_q}; end
			ST_VSQ, ST_LSQ: begin
				op_code = OP_SQRT;
				op_a    = mag_q;
			end
			ST_VDX, ST_VDY, ST_LDX, ST_LDY: begin
				op_code = OP_DIV;
				op_a    = tmp_q;
				op_b    = {37'd0, s_q};
			end
			default: begin
				op_code = OP_MUL;
			end
		endcase
	end

	assign op_start = cmd.start;

	csf_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (op_start),
		.op     (op_code),
		.a      (op_a),
		.b      (op_b),
		.done   (done),
		.res    (res)
	);

	// clamp to the frame and drop velocity pushing out past an edge
	always_comb begin
		x_lo    = px_q[18];
		x_hi    = !px_q[18] && (px_q[17:0] > 18'd65536);
		y_lo    = py_q[18];
		y_hi    = !py_q[18] && (py_q[17:0] > 18'd65536);
		px_cl   = x_lo ? 19'sd0 : (x_hi ? 19'sd65536 : px_q);
		py_cl   = y_lo ? 19'sd0 : (y_hi ? 19'sd65536 : py_q);
		vx_zero = (x_lo && vx_q[26]) || (x_hi && !vx_q[26] && (vx_q != 27'sd0));
		vy_zero = (y_lo && vy_q[26]) || (y_hi && !vy_q[26] && (vy_q != 27'sd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= STIFFNESS_RST;
			damp_q  <= DAMPING_RST;
			mspd_q  <= MAX_SPEED_RST;
			mlag_q  <= MAX_LAG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STIFFNESS: stiff_q <= cfg_data[15:0];
				REG_DAMPING:   damp_q  <= cfg_data[15:0];
				REG_MAX_SPEED: mspd_q  <= cfg_data;
				REG_MAX_LAG:   mlag_q  <= cfg_data[16:0];
				default:       stiff_q <= stiff_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= POS_CENTRE;
			py_q <= POS_CENTRE;
			vx_q <= '0;
			vy_q <= '0;
		end else if (cmd.load) begin
			if (restart) begin
				px_q <= {2'b00, tx_sat};
				py_q <= {2'b00, ty_sat};
				vx_q <= '0;
				vy_q <= '0;
			end
		end else if (cmd.step == ST_CLAMP) begin
			px_q <= px_cl;
			py_q <= py_cl;
			if (vx_zero)
				vx_q <= '0;
			if (vy_zero)
				vy_q <= '0;
		end else if (done) begin
			unique case (cmd.step)
				ST_VX:   vx_q <= vx_q + 27'(res);
				ST_VY:   vy_q <= vy_q + 27'(res);
				ST_VDX:  vx_q <= 27'(res);
				ST_VDY:  vy_q <= 27'(res);
				ST_PDX:  px_q <= px_q + 19'(res);
				ST_PDY:  py_q <= py_q + 19'(res);
				ST_LDX:  px_q <= 19'($signed({2'b00, tx_q})) - 19'(res);
				ST_LDY:  py_q <= 19'($signed({2'b00, ty_q})) - 19'(res);
				default: px_q <= px_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q  <= tx_sat;
			ty_q  <= ty_sat;
			dt_q  <= in_dt;
			rem_q <= step_us - in_dt;
		end else if (cmd.step == ST_CLAMP) begin
			dt_q  <= rem_dt;
			rem_q <= rem_q - rem_dt;
		end
		if (done) begin
			unique case (cmd.step)
				ST_KX, ST_KY, ST_AX, ST_AY, ST_VSX, ST_VSY,
				ST_PMX, ST_PMY, ST_LSX, ST_LSY: tmp_q <= res;
				ST_DX, ST_DY:                   tmp_q <= tmp_q - res;
				ST_VMX, ST_LMX:                 mag_q <= res;
				ST_VMY, ST_LMY:                 mag_q <= mag_q + res;
				ST_VSQ, ST_LSQ:                 s_q   <= res[26:0];
				default:                        tmp_q <= tmp_q;
			endcase
		end
		if (cmd.emit) begin
			pos_x_q <= px_q[16:0];
			pos_y_q <= py_q[16:0];
			vel_x_q <= vx_q[20:0];
			vel_y_q <= vy_q[20:0];
		end
	end

	assign sts.done      = done;
	assign sts.big       = mag_q > res;
	assign sts.rem_zero  = rem_q == 16'd0;
	assign sts.step_zero = step_us == 16'd0;

	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign vel_x = $signed(vel_x_q);
	assign vel_y = $signed(vel_y_q);

endmodule

FILE: sv/csf_ctrl.sv
// ----------------------------------------------------------------------------
// csf_ctrl: spring follower sequencer
// Walks each sub-step through the arithmetic unit one operation at a time,
// branches on the speed and lag limits and drives both handshakes.
// ----------------------------------------------------------------------------
module csf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  csf_pkg::csf_sts_t   sts,
	output csf_pkg::csf_cmd_t   cmd
);
	import csf_pkg::*;

	csf_state_t state_q, state_d;
	logic       issued_q, out_valid_q;
	logic       op_state, emit, accept;

	assign op_state = (state_q != ST_IDLE) && (state_q != ST_CLAMP) && (state_q != ST_OUT);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign emit     = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d   = state_q;
		cmd.step  = state_q;
		cmd.start = op_state && !issued_q;
		cmd.load  = accept;
		cmd.emit  = emit;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = sts.step_zero ? ST_OUT : ST_KX;
			ST_KX:    if (sts.done) state_d = ST_DX;
			ST_DX:    if (sts.done) state_d = ST_AX;
			ST_AX:    if (sts.done) state_d = ST_VX;
			ST_VX:    if (sts.done) state_d = ST_KY;
			ST_KY:    if (sts.done) state_d = ST_DY;
			ST_DY:    if (sts.done) state_d = ST_AY;
			ST_AY:    if (sts.done) state_d = ST_VY;
			ST_VY:    if (sts.done) state_d = ST_VMX;
			ST_VMX:   if (sts.done) state_d = ST_VMY;
			ST_VMY:   if (sts.done) state_d = ST_VLIM;
			ST_VLIM:  if (sts.done) state_d = sts.big ? ST_VSQ : ST_PMX;
			ST_VSQ:   if (sts.done) state_d = ST_VSX;
			ST_VSX:   if (sts.done) state_d = ST_VDX;
			ST_VDX:   if (sts.done) state_d = ST_VSY;
			ST_VSY:   if (sts.done) state_d = ST_VDY;
			ST_VDY:   if (sts.done) state_d = ST_PMX;
			ST_PMX:   if (sts.done) state_d = ST_PDX;
			ST_PDX:   if (sts.done) state_d = ST_PMY;
			ST_PMY:   if (sts.done) state_d = ST_PDY;
			ST_PDY:   if (sts.done) state_d = ST_LMX;
			ST_LMX:   if (sts.done) state_d = ST_LMY;
			ST_LMY:   if (sts.done) state_d = ST_LLIM;
			ST_LLIM:  if (sts.done) state_d = sts.big ? ST_LSQ : ST_CLAMP;
			ST_LSQ:   if (sts.done) state_d = ST_LSX;
			ST_LSX:   if (sts.done) state_d = ST_LDX;
			ST_LDX:   if (sts.done) state_d = ST_LSY;
			ST_LSY:   if (sts.done) state_d = ST_LDY;
			ST_LDY:   if (sts.done) state_d = ST_CLAMP;
			ST_CLAMP: state_d = sts.rem_zero ? ST_OUT : ST_KX;
			ST_OUT:   if (emit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.done)
				issued_q <= 1'b0;
			else if (cmd.start)
				issued_q <= 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

FILE: sv/cursor_spring_follower_unit.sv
// ----------------------------------------------------------------------------
// cursor_spring_follower_unit: 2-D damped spring pointer follower
// Each input item (target, tick length, restart) advances the pointer by one
// tick and returns one item holding the new position and velocity.
//
// Configuration: cfg_we writes cfg_data into register cfg_index (0 stiffness,
// 1 damping, 2 speed limit, 3 lag limit) at once; write only while idle.
// Input: in_valid/in_ready, taken only when no tick is in progress.
// A tick is cut into sub-steps of at most MAX_STEP_US microseconds. Each
// sub-step is a sequence of operations on one shared iterative unit:
// multiplies and fixed scaling divides, plus a square root, multiplies and
// divides by a variable for each of the speed and lag limits that bites.
// A zero-length tick skips the operations and goes straight to output.
// That unit sets the rate.
// Output: out_valid/out_ready from a result register; a stalled receiver
// holds the finished tick in the sequencer until the register frees up,
// while the previous result waits.
// Reset: pointer at the frame centre, velocity zero, registers at defaults.
// ----------------------------------------------------------------------------
module cursor_spring_follower_unit #(
	parameter int unsigned MAX_STEP_US = 16000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [16:0]         target_x,
	input  logic [16:0]         target_y,
	input  logic [15:0]         step_us,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [16:0]         pos_x,
	output logic [16:0]         pos_y,
	output logic signed [20:0]  vel_x,
	output logic signed [20:0]  vel_y
);
	import csf_pkg::*;

	csf_cmd_t cmd;
	csf_sts_t sts;

	csf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	csf_datapath #(
		.MAX_STEP_US (MAX_STEP_US)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.target_x  (target_x),
		.target_y  (target_y),
		.step_us   (step_us),
		.restart   (restart),
		.cmd       (cmd),
		.sts       (sts),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.vel_x     (vel_x),
		.vel_y     (vel_y)
	);

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cursor_spring_follower_unit
// A directed table covers reset state, restart, zero tick, saturated targets
// and tick lengths around the sub-step split. Random ticks follow over several
// register settings and idling phases. Each result is checked against the
// typed row expectation if any, else a tick-by-tick spring model in the bench.
// ----------------------------------------------------------------------------
module testbench;
	import csf_pkg::*;

	localparam int unsigned SUB_US  = 16000;
	localparam int          N_STALL = 3000;

	typedef struct packed {
		logic [16:0] px;
		logic [16:0] py;
		logic [20:0] vx;
		logic [20:0] vy;
	} pointer_t;

	typedef struct {
		logic [16:0] tx;
		logic [16:0] ty;
		logic [15:0] us;
		logic        rs;
		logic        typed;
		pointer_t    res;
	} tick_row_t;

	typedef struct {
		logic [15:0] k;
		logic [15:0] d;
		logic [19:0] vmax;
		logic [16:0] lag;
		int          mode;
		int          n;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_STIFFNESS;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [16:0] target_x = '0;
	logic [16:0] target_y = '0;
	logic [15:0] step_us = '0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [16:0] pos_x;
	logic [16:0] pos_y;
	logic signed [20:0] vel_x;
	logic signed [20:0] vel_y;

	// typed expectation travels with the item
	logic     cur_typed = 1'b0;
	pointer_t cur_res = '0;

	// bench copy of the spring
	longint k_q8, d_q8, vmax, lag_max;
	longint px, py, vx, vy;

	pointer_t pending[$];
	int       n_bad = 0;
	int       n_items = 0;
	int       n_results = 0;
	int       idle_pct = 0;
	int       stall_pct = 0;
	int       hold_left = 0;
	bit       hold_req = 0;

	cursor_spring_follower_unit u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(64'd400_000_000);
		$display("status: fail");
		$finish;
	end

	function automatic longint unsigned sqrt_up(longint unsigned n);
		longint unsigned r, b, x;
		r = 0;
		x = n;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (r * r < n) r++;
		return r;
	endfunction

	function automatic void spring_substep(longint tx, longint ty, longint dt);
		longint ax, ay, lx, ly, ox, oy, s;
		longint unsigned m2;
		ax = k_q8 * (tx - px) - d_q8 * vx;
		ay = k_q8 * (ty - py) - d_q8 * vy;
		vx += (ax * dt) / 256000000;
		vy += (ay * dt) / 256000000;
		m2 = vx * vx + vy * vy;
		if (m2 > vmax * vmax) begin
			s = sqrt_up(m2);
			vx = vx * vmax / s;
			vy = vy * vmax / s;
		end
		px += (vx * dt) / 1000000;
		py += (vy * dt) / 1000000;
		lx = tx - px;
		ly = ty - py;
		m2 = lx * lx + ly * ly;
		if (m2 > lag_max * lag_max) begin
			s = sqrt_up(m2);
			px = tx - lx * lag_max / s;
			py = ty - ly * lag_max / s;
		end
		ox = px;
		oy = py;
		if (ox < 0) px = 0;
		if (ox > 65536) px = 65536;
		if (oy < 0) py = 0;
		if (oy > 65536) py = 65536;
		if ((ox < 0 && vx < 0) || (ox > 65536 && vx > 0)) vx = 0;
		if ((oy < 0 && vy < 0) || (oy > 65536 && vy > 0)) vy = 0;
	endfunction

	function automatic pointer_t spring_tick(logic [16:0] tx_in, logic [16:0] ty_in,
			logic [15:0] us, logic rs);
		longint tx, ty, left, dt;
		pointer_t r;
		tx = longint'((tx_in > POS_ONE) ? POS_ONE : tx_in);
		ty = longint'((ty_in > POS_ONE) ? POS_ONE : ty_in);
		left = longint'(us);
		if (rs) begin
			px = tx;
			py = ty;
			vx = 0;
			vy = 0;
		end
		while (left > 0) begin
			dt = (left < SUB_US) ? left : SUB_US;
			spring_substep(tx, ty, dt);
			left -= dt;
		end
		r.px = px[16:0];
		r.py = py[16:0];
		r.vx = vx[20:0];
		r.vy = vy[20:0];
		return r;
	endfunction

	// check results, then record newly accepted ticks
	always @(posedge clk) begin
		pointer_t got, want;
		if (out_valid && out_ready) begin
			got = '{pos_x, pos_y, vel_x, vel_y};
			n_results++;
			if (pending.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch: expected px=%0d py=%0d vx=%0d vy=%0d, got px=%0d py=%0d vx=%0d vy=%0d",
							want.px, want.py, $signed(want.vx), $signed(want.vy),
							got.px, got.py, $signed(got.vx), $signed(got.vy));
				end
			end
		end
		if (in_valid && in_ready) begin
			want = spring_tick(target_x, target_y, step_us, restart);
			pending.push_back(cur_typed ? cur_res : want);
			n_items++;
		end
	end

	// receiver: random stall plus one long hold when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = N_STALL;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(setting_t s);
		write_reg(REG_STIFFNESS, 20'(s.k));
		write_reg(REG_DAMPING, 20'(s.d));
		write_reg(REG_MAX_SPEED, s.vmax);
		write_reg(REG_MAX_LAG, 20'(s.lag));
		k_q8 = longint'(s.k);
		d_q8 = longint'(s.d);
		vmax = longint'(s.vmax);
		lag_max = longint'(s.lag);
	endtask

	// offer one tick, hold it until taken, then idle at random
	task automatic send_tick(tick_row_t t);
		in_valid <= 1'b1;
		target_x <= t.tx;
		target_y <= t.ty;
		step_us <= t.us;
		restart <= t.rs;
		cur_typed <= t.typed;
		cur_res <= t.res;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic logic [16:0] rand_coord();
		int c;
		c = $urandom_range(99);
		if (c < 75) return 17'($urandom_range(65536));
		if (c < 85) return 17'($urandom_range(131071));
		if (c < 92) return ($urandom_range(1)) ? 17'd0 : POS_ONE;
		return 17'($urandom_range(65536 - 4000, 65536));
	endfunction

	function automatic tick_row_t rand_tick();
		tick_row_t t;
		int c;
		c = $urandom_range(99);
		t.tx = rand_coord();
		t.ty = rand_coord();
		if (c < 70) t.us = 16'($urandom_range(1, 16000));
		else if (c < 88) t.us = 16'($urandom_range(16001, 32000));
		else if (c < 97) t.us = 16'($urandom_range(65535));
		else t.us = 16'd0;
		t.rs = ($urandom_range(99) < 10);
		t.typed = 1'b0;
		t.res = '0;
		return t;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		tick_row_t table_rows[$];
		setting_t  plan[$];
		tick_row_t t;

		k_q8 = longint'(STIFFNESS_RST);
		d_q8 = longint'(DAMPING_RST);
		vmax = longint'(MAX_SPEED_RST);
		lag_max = longint'(MAX_LAG_RST);
		px = 32768;
		py = 32768;
		vx = 0;
		vy = 0;

		// zero tick after reset returns the centre, restart loads saturated target
		table_rows = '{
			'{17'd0, 17'd0, 16'd0, 1'b0, 1'b1, '{17'd32768, 17'd32768, 21'd0, 21'd0}},
			'{17'd0, 17'd0, 16'd0, 1'b1, 1'b1, '{17'd0, 17'd0, 21'd0, 21'd0}},
			'{17'd131071, 17'd131071, 16'd0, 1'b1, 1'b1,
				'{17'd65536, 17'd65536, 21'd0, 21'd0}},
			'{17'd65536, 17'd0, 16'd0, 1'b1, 1'b1, '{17'd65536, 17'd0, 21'd0, 21'd0}},
			'{17'd100, 17'd65537, 16'd0, 1'b1, 1'b1, '{17'd100, 17'd65536, 21'd0, 21'd0}},
			'{17'd1000, 17'd1000, 16'd16000, 1'b1, 1'b1,
				'{17'd1000, 17'd1000, 21'd0, 21'd0}},
			'{17'd0, 17'd65536, 16'd1, 1'b0, 1'b0, '0},
			'{17'd0, 17'd65536, 16'd16000, 1'b0, 1'b0, '0},
			'{17'd65536, 17'd0, 16'd16001, 1'b0, 1'b0, '0},
			'{17'd65536, 17'd65536, 16'd65535, 1'b0, 1'b0, '0},
			'{17'd0, 17'd0, 16'd32000, 1'b0, 1'b0, '0},
			'{17'd131071, 17'd0, 16'd5000, 1'b0, 1'b0, '0},
			'{17'd0, 17'd131071, 16'd40000, 1'b0, 1'b0, '0},
			'{17'd43690, 17'd21845, 16'd65535, 1'b1, 1'b0, '0},
			'{17'd0, 17'd65536, 16'd8000, 1'b1, 1'b0, '0},
			'{17'd65536, 17'd0, 16'd12000, 1'b0, 1'b0, '0},
			'{17'd32768, 17'd32768, 16'd1, 1'b0, 1'b0, '0},
			'{17'd1, 17'd65535, 16'd16000, 1'b0, 1'b0, '0}
		};

		plan = '{
			'{16'd65535, 16'd0, 20'd1048575, 17'd131071, 1, 280},
			'{16'd0, 16'd65535, 20'd0, 17'd0, 2, 280},
			'{STIFFNESS_RST, DAMPING_RST, MAX_SPEED_RST, 17'd65536, 3, 280},
			'{16'd4000, 16'd900, 20'd20000, 17'd500, 0, 280},
			'{16'd65535, 16'd65535, 20'd1000, MAX_LAG_RST, 2, 280}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, no idling
		foreach (table_rows[i]) send_tick(table_rows[i]);
		repeat (240) send_tick(rand_tick());
		drain();

		foreach (plan[p]) begin
			apply_setting(plan[p]);
			case (plan[p].mode)
				1: begin idle_pct = 59; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 59; end
				3: begin idle_pct = 8; stall_pct = 8; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			if (p == 1) hold_req = 1;
			repeat (plan[p].n) begin
				t = rand_tick();
				send_tick(t);
			end
			drain();
		end

		$display("ran %0d ticks over %0d register settings, %0d results seen",
			n_items, plan.size() + 1, n_results);
		if (n_bad == 0 && pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", n_bad, pending.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/csf_pkg.sv
sv/csf_arith.sv
sv/csf_datapath.sv
sv/csf_ctrl.sv
sv/cursor_spring_follower_unit.sv
verif/testbench.sv
